// ----- sv/olist_pkg.sv -----
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine: op and status
// codes, sequencer states and the compare result bundle.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int CAPACITY_DEF = 256;

   localparam int OP_W   = 3;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 11;

   localparam logic signed [VAL_W-1:0] NOT_FOUND = '1;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_READ   = 3'd2,
      OP_SEARCH = 3'd3,
      OP_MIN    = 3'd4,
      OP_DEDUP  = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT_UP,
      S_PUT,
      S_SCAN,
      S_DD_RDI,
      S_DD_GETI,
      S_DD_SCAN
   } state_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

endpackage

// ----- sv/ordered_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded positional list of signed words with insert, delete, read, search,
// minimum, duplicate removal and clear, run by a sequencer over one memory.
// ----------------------------------------------------------------------------
// clear, unused ops, empty-list insert and checks that fail answer from the decide
// state; read fetches one entry; search and minimum walk the list, search stopping
// at its first hit; insert shifts the tail up a place, then writes; delete copies
// the entries above down; remove duplicates scans the kept prefix for each entry.
// one word in flight; the next is taken at the edge that takes the reply, no stall.
// reset clears the entry count; entry memory is not initialized, no clear pass.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VAL_W-1:0]  req_value,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]  rsp_data,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic [POS_W-1:0]         rsp_removed
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   state_type state_ff, state_in;

   op_type                   op_ff, op_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [VAL_W-1:0]  val_ff, val_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            last_ff, last_in;
   logic [CW-1:0]            pidx_ff, pidx_in;
   logic [CW-1:0]            jdx_ff, jdx_in;
   logic [CW-1:0]            kept_ff, kept_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [CW-1:0]            bpos_ff, bpos_in;
   logic signed [VAL_W-1:0]  best_ff, best_in;
   logic signed [VAL_W-1:0]  cur_ff, cur_in;
   logic                     pend_ff, pend_in;
   logic                     hit_ff, hit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [POS_W-1:0]         rsp_removed_ff, rsp_removed_in;

   // memory and compare unit hookup
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic signed [VAL_W-1:0]  mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic signed [VAL_W-1:0]  mem_rdata;
   logic signed [VAL_W-1:0]  cmp_b;
   cmp_type                  cmp_res;

   logic                     fin;
   status_type               fin_status;
   logic signed [VAL_W-1:0]  fin_data;
   logic [CW-1:0]            fin_fpos;
   logic [CW-1:0]            fin_removed;
   logic                     issue;
   logic [CW-1:0]            idx_m1;
   logic [CW-1:0]            pidx_m1;
   logic [POS_W-1:0]         pos_m1;
   logic [CMPW-1:0]          pos_x;
   logic [CMPW-1:0]          cnt_x;
   logic [CMPW-1:0]          idx_x;

   olist_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   olist_cmp u_cmp (
      .a   (mem_rdata),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign idx_m1  = idx_ff - 1'b1;
   assign pidx_m1 = pidx_ff - 1'b1;
   assign pos_m1  = pos_ff - 1'b1;
   assign pos_x   = CMPW'(pos_ff);
   assign cnt_x   = CMPW'(cnt_ff);
   assign idx_x   = CMPW'(idx_ff);

   always_comb begin
      case (op_ff)
         OP_SEARCH: cmp_b = val_ff;
         OP_MIN:    cmp_b = best_ff;
         default:   cmp_b = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      pidx_in     = pidx_ff;
      jdx_in      = jdx_ff;
      kept_in     = kept_ff;
      rem_in      = rem_ff;
      bpos_in     = bpos_ff;
      best_in     = best_ff;
      cur_in      = cur_ff;
      pend_in     = 1'b0;
      hit_in      = hit_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = val_ff;
      mem_raddr   = '0;
      issue       = 1'b0;
      fin         = 1'b0;
      fin_status  = ST_OK;
      fin_data    = '0;
      fin_fpos    = '0;
      fin_removed = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op_type'(req_op);
               pos_in   = req_position;
               val_in   = req_value;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            hit_in = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (cnt_ff >= CAP_CNT) begin
                     fin        = 1'b1;
                     fin_status = ST_FULL;
                  end else if (cnt_ff == '0) begin
                     // empty list takes any position as the first entry
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     cnt_in    = CW'(1);
                     fin       = 1'b1;
                  end else if (pos_ff == '0 || pos_x > cnt_x + CMPW'(1)) begin
                     fin        = 1'b1;
                     fin_status = ST_RANGE;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
               OP_DELETE: begin
                  if (cnt_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else if (pos_ff == '0 || pos_x > cnt_x) begin
                     fin        = 1'b1;
                     fin_status = ST_RANGE;
                  end else begin
                     idx_in   = CW'(pos_ff);
                     last_in  = cnt_ff;
                     state_in = S_SCAN;
                  end
               end
               OP_READ: begin
                  if (cnt_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                     fin_data   = NOT_FOUND;
                  end else if (pos_ff == '0 || pos_x > cnt_x) begin
                     fin        = 1'b1;
                     fin_status = ST_RANGE;
                     fin_data   = NOT_FOUND;
                  end else begin
                     idx_in   = CW'(pos_m1);
                     last_in  = CW'(pos_ff);
                     state_in = S_SCAN;
                  end
               end
               OP_SEARCH, OP_MIN: begin
                  if (cnt_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                     fin_data   = NOT_FOUND;
                  end else begin
                     idx_in   = '0;
                     last_in  = cnt_ff;
                     state_in = S_SCAN;
                  end
               end
               OP_DEDUP: begin
                  idx_in   = '0;
                  kept_in  = '0;
                  rem_in   = '0;
                  state_in = S_DD_RDI;
               end
               OP_CLEAR: begin
                  cnt_in = '0;
                  fin    = 1'b1;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         // move entries up one place, top down, reading one ahead of the write
         S_SHIFT_UP: begin
            issue = (idx_x >= pos_x);
            if (issue) begin
               mem_raddr = idx_m1[AW-1:0];
               pidx_in   = idx_ff;
               idx_in    = idx_m1;
            end
            pend_in = issue;
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pidx_ff[AW-1:0];
               mem_wdata = mem_rdata;
            end
            if (!issue && !pend_ff) begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_m1);
            cnt_in    = cnt_ff + 1'b1;
            fin       = 1'b1;
         end

         // upward walk shared by delete, read, search and minimum
         S_SCAN: begin
            issue = (idx_ff < last_ff) && !hit_ff;
            if (issue) begin
               mem_raddr = idx_ff[AW-1:0];
               pidx_in   = idx_ff;
               idx_in    = idx_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff) begin
               case (op_ff)
                  OP_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pidx_m1[AW-1:0];
                     mem_wdata = mem_rdata;
                  end
                  OP_SEARCH: begin
                     if (!hit_ff && cmp_res.eq) begin
                        hit_in  = 1'b1;
                        bpos_in = pidx_ff;
                     end
                  end
                  OP_MIN: begin
                     if (pidx_ff == '0 || cmp_res.lt) begin
                        best_in = mem_rdata;
                        bpos_in = pidx_ff;
                     end
                  end
                  default: begin
                     best_in = mem_rdata;
                  end
               endcase
            end
            if (!issue && !pend_ff) begin
               fin = 1'b1;
               case (op_ff)
                  OP_DELETE: begin
                     cnt_in = cnt_ff - 1'b1;
                  end
                  OP_SEARCH: begin
                     if (hit_ff) begin
                        fin_data = val_ff;
                        fin_fpos = bpos_ff + 1'b1;
                     end else begin
                        fin_status = ST_RANGE;
                        fin_data   = NOT_FOUND;
                     end
                  end
                  OP_MIN: begin
                     fin_data = best_ff;
                     fin_fpos = bpos_ff + 1'b1;
                  end
                  default: begin
                     fin_data = best_ff;
                  end
               endcase
            end
         end

         S_DD_RDI: begin
            if (idx_ff == cnt_ff) begin
               cnt_in      = kept_ff;
               fin         = 1'b1;
               fin_removed = rem_ff;
            end else begin
               mem_raddr = idx_ff[AW-1:0];
               state_in  = S_DD_GETI;
            end
         end

         S_DD_GETI: begin
            cur_in   = mem_rdata;
            jdx_in   = '0;
            hit_in   = 1'b0;
            state_in = S_DD_SCAN;
         end

         // look for the current word among the kept prefix
         S_DD_SCAN: begin
            issue = (jdx_ff < kept_ff) && !hit_ff;
            if (issue) begin
               mem_raddr = jdx_ff[AW-1:0];
               jdx_in    = jdx_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff && cmp_res.eq) begin
               hit_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               if (hit_ff) begin
                  rem_in = rem_ff + 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = kept_ff[AW-1:0];
                  mem_wdata = cur_ff;
                  kept_in   = kept_ff + 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = S_DD_RDI;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in   = fin;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_fpos_in    = rsp_fpos_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_removed_in = rsp_removed_ff;
      if (fin) begin
         state_in       = S_IDLE;
         rsp_status_in  = fin_status;
         rsp_data_in    = fin_data;
         rsp_fpos_in    = POS_W'(fin_fpos);
         rsp_count_in   = CNT_W'(cnt_in);
         rsp_removed_in = POS_W'(fin_removed);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      idx_ff         <= idx_in;
      last_ff        <= last_in;
      pidx_ff        <= pidx_in;
      jdx_ff         <= jdx_in;
      kept_ff        <= kept_in;
      rem_ff         <= rem_in;
      bpos_ff        <= bpos_in;
      best_ff        <= best_in;
      cur_ff         <= cur_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_fpos_ff    <= rsp_fpos_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_removed        = rsp_removed_ff;

endmodule

// ----- sv/olist_mem.sv -----
// ----------------------------------------------------------------------------
// olist_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_mem
   import olist_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [VAL_W-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [VAL_W-1:0]    rd_data
);

   logic signed [VAL_W-1:0] mem_ff [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/olist_cmp.sv -----
// ----------------------------------------------------------------------------
// olist_cmp
// Shared compare unit: equality and signed less-than of a memory word
// against the operand the sequencer selects.
// ----------------------------------------------------------------------------
module olist_cmp
   import olist_pkg::*;
(
   input  logic signed [VAL_W-1:0] a,
   input  logic signed [VAL_W-1:0] b,
   output cmp_type                 res
);

   always_comb begin
      res.eq = (a == b);
      res.lt = (a < b);
   end

endmodule

// ----- tb/tb_ordered_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_unit
// Self-checking bench for the ordered list engine. A short table of directed
// words covers the empty list, range errors, extreme values and every op.
// A fill to full capacity follows, then rounds of random words with bounded
// list sizes. Every reply is checked field by field against the reply given in
// the table for typed rows, else against a shadow list kept in the bench.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_unit;
   import olist_pkg::*;

   localparam int LIST_CAP      = CAPACITY_DEF;
   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ROUNDS = 10;
   localparam int ROUND_WORDS   = 106;
   localparam int TAIL_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 8_000_000;

   localparam logic [OP_W-1:0]  OP_UNUSED = 3'd7;
   localparam logic [POS_W-1:0] POS_TOP   = '1;
   localparam bit               TYPED     = 1'b1;
   localparam bit               CALC      = 1'b0;

   typedef struct packed {
      status_type         status;
      logic [VAL_W-1:0]   data;
      logic [POS_W-1:0]   found_position;
      logic [CNT_W-1:0]   entry_count;
      logic [POS_W-1:0]   removed;
   } list_reply_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   value;
      logic               typed;
      list_reply_type     reply;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_op;
   logic [POS_W-1:0]         req_position;
   logic signed [VAL_W-1:0]  req_value;
   logic                     rsp_strobe;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [VAL_W-1:0]  rsp_data;
   logic [POS_W-1:0]         rsp_found_position;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic [POS_W-1:0]         rsp_removed;

   logic [VAL_W-1:0] shadow_entries[$];
   list_reply_type   pending_replies[$];
   stim_row_type     directed_rows[$];

   int mismatch_count;
   int reply_count;
   int cycle_count;
   int peak_count;
   int quiet_left;
   int op_seen[8];

   ordered_list_engine_unit #(
      .CAPACITY(LIST_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_found_position(rsp_found_position),
      .rsp_entry_count(rsp_entry_count),
      .rsp_removed(rsp_removed)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles with %0d replies pending",
               cycle_count, pending_replies.size());
      $display("tb_ordered_list_engine_unit NOT OK");
      $finish;
   end

   // applies one op to the shadow list and returns the reply it should give
   function automatic list_reply_type apply_list_op(input logic [OP_W-1:0] op,
                                                    input logic [POS_W-1:0] position,
                                                    input logic [VAL_W-1:0] value);
      list_reply_type   r;
      logic [VAL_W-1:0] kept[$];
      int               n;
      int               i;
      int               j;
      int               best;
      bit               dup;
      r = '0;
      r.status = ST_OK;
      n = shadow_entries.size();
      case (op)
         OP_INSERT: begin
            if (n >= LIST_CAP) r.status = ST_FULL;
            else if (n == 0) shadow_entries.push_back(value);
            else if (position == 0 || position > n + 1) r.status = ST_RANGE;
            else shadow_entries.insert(position - 1, value);
         end
         OP_DELETE: begin
            if (n == 0) r.status = ST_EMPTY;
            else if (position == 0 || position > n) r.status = ST_RANGE;
            else shadow_entries.delete(position - 1);
         end
         OP_READ: begin
            r.data = NOT_FOUND;
            if (n == 0) r.status = ST_EMPTY;
            else if (position == 0 || position > n) r.status = ST_RANGE;
            else r.data = shadow_entries[position - 1];
         end
         OP_SEARCH: begin
            r.data = NOT_FOUND;
            if (n == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_RANGE;
               for (i = 0; i < n && r.found_position == 0; i++) begin
                  if (shadow_entries[i] == value) begin
                     r.status = ST_OK;
                     r.data = value;
                     r.found_position = POS_W'(i + 1);
                  end
               end
            end
         end
         OP_MIN: begin
            if (n == 0) begin
               r.status = ST_EMPTY;
               r.data = NOT_FOUND;
            end else begin
               // first smallest wins, compared as signed
               best = 0;
               for (i = 1; i < n; i++) begin
                  if ($signed(shadow_entries[i]) < $signed(shadow_entries[best])) best = i;
               end
               r.data = shadow_entries[best];
               r.found_position = POS_W'(best + 1);
            end
         end
         OP_DEDUP: begin
            for (i = 0; i < n; i++) begin
               dup = 1'b0;
               for (j = 0; j < kept.size(); j++) begin
                  if (kept[j] == shadow_entries[i]) dup = 1'b1;
               end
               if (dup) r.removed = r.removed + 1'b1;
               else kept.push_back(shadow_entries[i]);
            end
            shadow_entries = kept;
         end
         OP_CLEAR: begin
            shadow_entries.delete();
         end
         default: begin
         end
      endcase
      r.entry_count = CNT_W'(shadow_entries.size());
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      // small values repeat often, which feeds search hits and duplicates
      if (r < 5) return $urandom_range(0, 15) - 8;
      if (r < 7) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return POS_W'($urandom_range(1, (top < 1) ? 1 : top));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return POS_W'(top);
            2: return POS_W'(top + 1);
            default: return POS_TOP;
         endcase
      end
      return POS_W'($urandom_range(0, POS_TOP));
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                          input logic [VAL_W-1:0] value, input bit typed,
                          input status_type status, input logic [VAL_W-1:0] data,
                          input logic [POS_W-1:0] found_position,
                          input logic [CNT_W-1:0] entry_count,
                          input logic [POS_W-1:0] removed);
      stim_row_type row;
      row.op                   = op;
      row.position             = position;
      row.value                = value;
      row.typed                = typed;
      row.reply.status         = status;
      row.reply.data           = data;
      row.reply.found_position = found_position;
      row.reply.entry_count    = entry_count;
      row.reply.removed        = removed;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                            input logic [VAL_W-1:0] value, input bit typed,
                            input list_reply_type typed_reply);
      int             gap;
      list_reply_type predicted;
      if (quiet_left > 0) begin
         gap = 0;
         quiet_left--;
      end else begin
         if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(8, 40);
         gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_position <= position;
      req_value    <= value;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_list_op(op, position, value);
      pending_replies.push_back(typed ? typed_reply : predicted);
      op_seen[op]++;
      if (shadow_entries.size() > peak_count) peak_count = shadow_entries.size();
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : reply_check
      list_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("reply word with nothing pending: status %0d, data 0x%0h",
                   rsp_status, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            reply_count++;
            check_field("status", want.status, rsp_status);
            check_field("data", want.data, rsp_data);
            check_field("found_position", want.found_position, rsp_found_position);
            check_field("entry_count", want.entry_count, rsp_entry_count);
            check_field("removed", want.removed, rsp_removed);
         end
      end
   end

   initial begin : stimulus
      int               round;
      int               k;
      int               r;
      int               n;
      int               top;
      int               size_cap;
      int               total;
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] val;

      reset        = 1'b1;
      start        = 1'b0;
      req_op       = OP_INSERT;
      req_position = '0;
      req_value    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list
      add_row(OP_READ,   10'd1, 32'd0, TYPED, ST_EMPTY, NOT_FOUND, 0, 0, 0);
      add_row(OP_DELETE, 10'd1, 32'd0, TYPED, ST_EMPTY, 32'd0, 0, 0, 0);
      add_row(OP_SEARCH, 10'd0, 32'd5, TYPED, ST_EMPTY, NOT_FOUND, 0, 0, 0);
      add_row(OP_MIN,    10'd0, 32'd0, TYPED, ST_EMPTY, NOT_FOUND, 0, 0, 0);
      add_row(OP_DEDUP,  10'd0, 32'd0, TYPED, ST_OK, 32'd0, 0, 0, 0);
      // any position inserts into an empty list
      add_row(OP_INSERT, POS_TOP, 32'h7FFF_FFFF, TYPED, ST_OK, 32'd0, 0, 1, 0);
      add_row(OP_INSERT, 10'd0, 32'h8000_0000, TYPED, ST_RANGE, 32'd0, 0, 1, 0);
      add_row(OP_INSERT, 10'd3, 32'h8000_0000, TYPED, ST_RANGE, 32'd0, 0, 1, 0);
      add_row(OP_INSERT, 10'd1, 32'h8000_0000, TYPED, ST_OK, 32'd0, 0, 2, 0);
      add_row(OP_INSERT, 10'd3, 32'hFFFF_FFFF, TYPED, ST_OK, 32'd0, 0, 3, 0);
      add_row(OP_INSERT, 10'd2, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_INSERT, 10'd5, 32'h7FFF_FFFF, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_READ,   10'd0, 32'd0, TYPED, ST_RANGE, NOT_FOUND, 0, 5, 0);
      add_row(OP_READ,   10'd6, 32'd0, TYPED, ST_RANGE, NOT_FOUND, 0, 5, 0);
      add_row(OP_READ,   POS_TOP, 32'd0, TYPED, ST_RANGE, NOT_FOUND, 0, 5, 0);
      add_row(OP_READ,   10'd5, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_SEARCH, 10'd0, 32'h7FFF_FFFF, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_SEARCH, 10'd0, 32'd12345, TYPED, ST_RANGE, NOT_FOUND, 0, 5, 0);
      add_row(OP_MIN,    10'd0, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_INSERT, 10'd1, 32'hFFFF_FFFF, CALC, ST_OK, 32'd0, 0, 0, 0);
      // a hit on -1 must still report ok
      add_row(OP_SEARCH, 10'd0, 32'hFFFF_FFFF, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_DEDUP,  10'd0, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_DELETE, 10'd0, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_DELETE, POS_TOP, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_DELETE, 10'd1, 32'd0, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_UNUSED, 10'd1, 32'hDEAD_BEEF, CALC, ST_OK, 32'd0, 0, 0, 0);
      add_row(OP_CLEAR,  10'd0, 32'd0, TYPED, ST_OK, 32'd0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].op, directed_rows[i].position, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].reply);
      end
      pause_until_drained();

      // fill to capacity with many repeats, then work the full list
      while (shadow_entries.size() < LIST_CAP) begin
         val = $urandom_range(0, 1) ? $urandom_range(0, 63) : pick_value();
         send_word(OP_INSERT, POS_W'($urandom_range(1, shadow_entries.size() + 1)),
                   val, CALC, '0);
      end
      send_word(OP_INSERT, 10'd0, pick_value(), CALC, '0);
      send_word(OP_INSERT, pick_position(LIST_CAP + 1), pick_value(), CALC, '0);
      send_word(OP_READ, POS_W'(LIST_CAP), pick_value(), CALC, '0);
      send_word(OP_READ, POS_W'(LIST_CAP + 1), pick_value(), CALC, '0);
      send_word(OP_SEARCH, pick_position(0), shadow_entries[LIST_CAP - 1], CALC, '0);
      send_word(OP_MIN, pick_position(0), pick_value(), CALC, '0);
      send_word(OP_DELETE, POS_W'(LIST_CAP), pick_value(), CALC, '0);
      send_word(OP_INSERT, POS_W'(LIST_CAP), pick_value(), CALC, '0);
      send_word(OP_DEDUP, pick_position(0), pick_value(), CALC, '0);
      send_word(OP_MIN, pick_position(0), pick_value(), CALC, '0);
      send_word(OP_CLEAR, pick_position(0), pick_value(), CALC, '0);
      pause_until_drained();

      // random rounds, each with its own bound on list size
      for (round = 0; round < RANDOM_ROUNDS; round++) begin
         r = $urandom_range(0, 9);
         size_cap = (r < 2) ? 2 : (r < 6) ? 12 : 48;
         for (k = 0; k < ROUND_WORDS; k++) begin
            n = shadow_entries.size();
            r = $urandom_range(0, 99);
            if (r < 35) op = (n >= size_cap) ? OP_DELETE : OP_INSERT;
            else if (r < 50) op = OP_DELETE;
            else if (r < 64) op = OP_READ;
            else if (r < 77) op = OP_SEARCH;
            else if (r < 86) op = OP_MIN;
            else if (r < 94) op = OP_DEDUP;
            else if (r < 98) op = OP_CLEAR;
            else op = OP_UNUSED;
            top = (op == OP_INSERT) ? n + 1 : n;
            if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1))
               val = shadow_entries[$urandom_range(0, n - 1)];
            else
               val = pick_value();
            send_word(op, pick_position(top), val, CALC, '0);
            if ($urandom_range(0, 99) == 0) pause_until_drained();
         end
         pause_until_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      total = 0;
      foreach (op_seen[i]) total += op_seen[i];
      $display("sent %0d words: insert %0d, delete %0d, read %0d, search %0d,",
               total, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_READ],
               op_seen[OP_SEARCH]);
      $display("   min %0d, dedup %0d, clear %0d, unused %0d",
               op_seen[OP_MIN], op_seen[OP_DEDUP], op_seen[OP_CLEAR],
               op_seen[OP_UNUSED]);
      $display("list peaked at %0d of %0d entries; %0d replies checked,",
               peak_count, LIST_CAP, reply_count);
      $display("   %0d mismatches, %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("tb_ordered_list_engine_unit OK");
      else
         $display("tb_ordered_list_engine_unit NOT OK");
      $finish;
   end

endmodule

// ----- ordered_list_engine_unit.f -----
sv/olist_pkg.sv
sv/olist_mem.sv
sv/olist_cmp.sv
sv/ordered_list_engine_unit.sv
tb/tb_ordered_list_engine_unit.sv
